>>> hdl/olisr_pkg.sv
// ----------------------------------------------------------------------------
// olisr_pkg
// Shared types and constants for the ordered list block: command and status
// codes, sequencer states and the slot allocator request.
// ----------------------------------------------------------------------------
package olisr_pkg;

  // Default node pool size
  localparam int unsigned DefCapacity = 64;

  // Width of the data values held in the list
  localparam int unsigned ValueW = 32;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_SEARCH = 2'd1,
    CMD_REMOVE = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_ABSENT = 2'd1,
    ST_FULL   = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_APP_POP,
    S_APP_NODE,
    S_APP_LINK,
    S_WALK,
    S_RESP
  } seq_state_e;

  // Requests from the sequencer to the slot allocator
  typedef struct packed {
    logic pop;   // take a free slot, delivered next cycle
    logic push;  // return a slot to the free pool
  } alloc_req_t;

endpackage

>>> hdl/ordered_list_insert_search_remove.sv
// ----------------------------------------------------------------------------
// ordered_list_insert_search_remove
// Insertion-ordered ring of values in a pool of linked nodes.
// Append steps through slot pop, node write and ring link, skipping the link
// into an empty list; search and remove walk the nodes one by one (up to
// CAPACITY), one node read per cycle from the node RAMs. Empty, full and unused
// commands go straight to the response step. One item is worked at a time; the
// next is taken in the cycle after its result is loaded, while that result waits to be taken.
// Reset clears the count and allocator; node RAMs are not cleared.
// ----------------------------------------------------------------------------
module ordered_list_insert_search_remove
  import olisr_pkg::*;
#(
  parameter int unsigned CAPACITY = DefCapacity,
  parameter int unsigned SlotW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  parameter int unsigned CntW     = $clog2(CAPACITY + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        command_i,
  input  logic [ValueW-1:0] value_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        status_o,
  output logic [CntW-1:0]   entry_count_o
);

  seq_state_e       state_q, state_d;
  logic [1:0]       cmd_q, cmd_d;
  logic [ValueW-1:0] val_q, val_d;
  logic [SlotW-1:0] first_q, first_d;
  logic [SlotW-1:0] last_q, last_d;
  logic [CntW-1:0]  used_q, used_d;
  logic [SlotW-1:0] ptr_q, ptr_d;
  logic [CntW-1:0]  visit_q, visit_d;
  logic [SlotW-1:0] slot_q, slot_d;
  status_e          res_q, res_d;
  logic             out_valid_q, out_valid_d;
  logic [1:0]       status_q, status_d;
  logic [CntW-1:0]  count_q, count_d;

  // Node RAM ports
  logic [SlotW-1:0]  rd_addr;
  logic              val_we, fwd_we, bwd_we;
  logic [SlotW-1:0]  val_waddr, fwd_waddr, bwd_waddr;
  logic [ValueW-1:0] val_wdata;
  logic [SlotW-1:0]  fwd_wdata, bwd_wdata;
  logic [ValueW-1:0] val_rdata;
  logic [SlotW-1:0]  fwd_rdata, bwd_rdata;

  alloc_req_t       alloc_req;
  logic [SlotW-1:0] alloc_slot;
  logic             accept;
  logic             out_free;

  olisr_ram #(.Width(ValueW), .Depth(CAPACITY), .AddrW(SlotW)) u_value (
    .clk_i(clk_i), .we_i(val_we), .waddr_i(val_waddr), .wdata_i(val_wdata),
    .raddr_i(rd_addr), .rdata_o(val_rdata)
  );

  olisr_ram #(.Width(SlotW), .Depth(CAPACITY), .AddrW(SlotW)) u_forward (
    .clk_i(clk_i), .we_i(fwd_we), .waddr_i(fwd_waddr), .wdata_i(fwd_wdata),
    .raddr_i(rd_addr), .rdata_o(fwd_rdata)
  );

  olisr_ram #(.Width(SlotW), .Depth(CAPACITY), .AddrW(SlotW)) u_backward (
    .clk_i(clk_i), .we_i(bwd_we), .waddr_i(bwd_waddr), .wdata_i(bwd_wdata),
    .raddr_i(rd_addr), .rdata_o(bwd_rdata)
  );

  olisr_alloc #(.Capacity(CAPACITY), .SlotW(SlotW), .CntW(CntW)) u_alloc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (alloc_req),
    .free_slot_i (ptr_q),
    .slot_o      (alloc_slot)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;

  // Sequencer: next state, list registers and RAM accesses
  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    val_d     = val_q;
    first_d   = first_q;
    last_d    = last_q;
    used_d    = used_q;
    ptr_d     = ptr_q;
    visit_d   = visit_q;
    slot_d    = slot_q;
    res_d     = res_q;
    rd_addr   = ptr_q;
    val_we    = 1'b0;
    fwd_we    = 1'b0;
    bwd_we    = 1'b0;
    val_waddr = slot_q;
    fwd_waddr = slot_q;
    bwd_waddr = slot_q;
    val_wdata = val_q;
    fwd_wdata = first_q;
    bwd_wdata = last_q;
    alloc_req = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_d   = command_i;
          val_d   = value_i;
          rd_addr = first_q;
          ptr_d   = first_q;
          visit_d = CntW'(1);
          priority case (command_i)
            CMD_APPEND: begin
              if (used_q == CntW'(CAPACITY)) begin
                res_d   = ST_FULL;
                state_d = S_RESP;
              end else begin
                state_d = S_APP_POP;
              end
            end
            CMD_SEARCH, CMD_REMOVE: begin
              if (used_q == '0) begin
                res_d   = ST_ABSENT;
                state_d = S_RESP;
              end else begin
                state_d = S_WALK;
              end
            end
            default: begin
              res_d   = ST_ABSENT;
              state_d = S_RESP;
            end
          endcase
        end
      end

      // Take a free slot
      S_APP_POP: begin
        alloc_req.pop = 1'b1;
        state_d       = S_APP_NODE;
      end

      // Write the new node; a lone node links to itself
      S_APP_NODE: begin
        slot_d    = alloc_slot;
        val_we    = 1'b1;
        fwd_we    = 1'b1;
        bwd_we    = 1'b1;
        val_waddr = alloc_slot;
        fwd_waddr = alloc_slot;
        bwd_waddr = alloc_slot;
        if (used_q == '0) begin
          fwd_wdata = alloc_slot;
          bwd_wdata = alloc_slot;
          first_d   = alloc_slot;
          last_d    = alloc_slot;
          used_d    = used_q + CntW'(1);
          res_d     = ST_OK;
          state_d   = S_RESP;
        end else begin
          state_d = S_APP_LINK;
        end
      end

      // Close the ring through the new tail
      S_APP_LINK: begin
        fwd_we    = 1'b1;
        bwd_we    = 1'b1;
        fwd_waddr = last_q;
        fwd_wdata = slot_q;
        bwd_waddr = first_q;
        bwd_wdata = slot_q;
        last_d    = slot_q;
        used_d    = used_q + CntW'(1);
        res_d     = ST_OK;
        state_d   = S_RESP;
      end

      // Check one node per cycle, advance along the forward link
      S_WALK: begin
        if (val_rdata == val_q) begin
          res_d   = ST_OK;
          state_d = S_RESP;
          if (cmd_q == CMD_REMOVE) begin
            alloc_req.push = 1'b1;
            used_d         = used_q - CntW'(1);
            if (used_q != CntW'(1)) begin
              bwd_we    = 1'b1;
              bwd_waddr = fwd_rdata;
              bwd_wdata = bwd_rdata;
              fwd_we    = 1'b1;
              fwd_waddr = bwd_rdata;
              fwd_wdata = fwd_rdata;
              if (ptr_q == first_q) begin
                first_d = fwd_rdata;
              end
              if (ptr_q == last_q) begin
                last_d = bwd_rdata;
              end
            end
          end
        end else if (visit_q == used_q) begin
          res_d   = ST_ABSENT;
          state_d = S_RESP;
        end else begin
          rd_addr = fwd_rdata;
          ptr_d   = fwd_rdata;
          visit_d = visit_q + CntW'(1);
        end
      end

      // Hand the result to the output register once it is free
      S_RESP: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output register: load on completion, drop once taken
  always_comb begin
    out_valid_d = out_valid_q;
    status_d    = status_q;
    count_d     = count_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if ((state_q == S_RESP) && out_free) begin
      out_valid_d = 1'b1;
      status_d    = res_q;
      count_d     = used_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      first_q     <= '0;
      last_q      <= '0;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      first_q     <= first_d;
      last_q      <= last_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    val_q    <= val_d;
    ptr_q    <= ptr_d;
    visit_q  <= visit_d;
    slot_q   <= slot_d;
    res_q    <= res_d;
    status_q <= status_d;
    count_q  <= count_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign entry_count_o = count_q;

  // The count never exceeds the pool
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CntW'(CAPACITY))
    else $error("list count exceeds capacity");

  // An append only takes a slot while the pool has room
  a_pop_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_APP_POP) |-> (used_q < CntW'(CAPACITY)))
    else $error("slot taken from a full pool");

  // A walk never visits more nodes than are linked
  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |-> ((visit_q != '0) && (visit_q <= used_q)))
    else $error("walk ran past the list");

  // A new result only comes from the response step
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_RESP))
    else $error("result raised outside the response step");

endmodule

>>> hdl/olisr_ram.sv
// ----------------------------------------------------------------------------
// olisr_ram
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read. Contents are not reset.
// ----------------------------------------------------------------------------
module olisr_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/olisr_alloc.sv
// ----------------------------------------------------------------------------
// olisr_alloc
// Free slot allocator: slots never used yet come from a high-water counter,
// freed slots go onto a stack kept in a RAM. A pop delivers its slot on the
// following cycle.
// ----------------------------------------------------------------------------
module olisr_alloc
  import olisr_pkg::*;
#(
  parameter int unsigned Capacity = DefCapacity,
  parameter int unsigned SlotW    = (Capacity > 1) ? $clog2(Capacity) : 1,
  parameter int unsigned CntW     = $clog2(Capacity + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  alloc_req_t       req_i,
  input  logic [SlotW-1:0] free_slot_i,
  output logic [SlotW-1:0] slot_o
);

  logic [CntW-1:0]  top_q, top_d;
  logic [CntW-1:0]  hwm_q, hwm_d;
  logic             from_stack_q, from_stack_d;
  logic [SlotW-1:0] fresh_q, fresh_d;
  logic [CntW-1:0]  top_dec;
  logic [SlotW-1:0] stack_rdata;

  assign top_dec = top_q - CntW'(1);

  // Free slot stack
  olisr_ram #(
    .Width (SlotW),
    .Depth (Capacity),
    .AddrW (SlotW)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (req_i.push),
    .waddr_i (top_q[SlotW-1:0]),
    .wdata_i (free_slot_i),
    .raddr_i (top_dec[SlotW-1:0]),
    .rdata_o (stack_rdata)
  );

  // A push takes priority; a pop takes from the stack when it holds a slot, else advances the high-water mark
  always_comb begin
    top_d        = top_q;
    hwm_d        = hwm_q;
    from_stack_d = from_stack_q;
    fresh_d      = fresh_q;
    if (req_i.push) begin
      top_d = top_q + CntW'(1);
    end else if (req_i.pop) begin
      if (top_q != '0) begin
        top_d        = top_dec;
        from_stack_d = 1'b1;
      end else begin
        hwm_d        = hwm_q + CntW'(1);
        fresh_d      = hwm_q[SlotW-1:0];
        from_stack_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q        <= '0;
      hwm_q        <= '0;
      from_stack_q <= 1'b0;
    end else begin
      top_q        <= top_d;
      hwm_q        <= hwm_d;
      from_stack_q <= from_stack_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fresh_q <= fresh_d;
  end

  assign slot_o = from_stack_q ? stack_rdata : fresh_q;

endmodule
